@@ hdl/battery_charge_level_monitor_defines.svh @@
// Assertion macros used by the datapath of the battery charge level monitor.
// Needs a clock aclk and an active-low reset aresetn in the using module.
`ifndef BATTERY_CHARGE_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_CHARGE_LEVEL_MONITOR_DEFINES_SVH

// Consequent checked in the same cycle.
`define BCLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bclm_pkg.sv @@
// Types and constants of the battery charge level monitor.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package bclm_pkg;

    typedef enum logic [1:0] {
        KIND_ADC, KIND_MV, KIND_CHARGER, KIND_POINT
    } item_kind_t;

    typedef enum logic [2:0] {
        BS_UNKNOWN, BS_NORMAL, BS_LOW, BS_FULL, BS_CHARGING
    } bat_state_t;

    typedef enum logic [2:0] {
        REG_CELL_COUNT, REG_CELL_FULL, REG_CELL_EMPTY, REG_CELL_LOW,
        REG_ADC_NUM, REG_ADC_DEN, REG_WINDOW_LEN, REG_CURVE_POINTS
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ADC_MUL, OP_ADC_DIV, OP_TAKE, OP_SLOT, OP_SUM, OP_AVG_DIV,
        OP_AVG, OP_CELL_DIV, OP_CELL, OP_LIN, OP_CRV_LAST, OP_CRV_FIRST,
        OP_CRV_CHK, OP_PCT_END, OP_REFRESH, OP_CHARGER, OP_POINT, OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_ADC_MUL, S_ADC_DIV, S_ADC_WAIT, S_TAKE, S_SLOT_WAIT,
        S_SUM_RD, S_SUM_ACC, S_AVG_DIV, S_AVG_WAIT, S_CELL_DIV, S_CELL_WAIT,
        S_PCT_SEL, S_CRV_LAST, S_CRV_LRD, S_CRV_LCAP, S_CRV_RD, S_CRV_CHK,
        S_PCT_WAIT, S_REFRESH, S_CHARGER, S_POINT, S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sum_last;
        logic curve_mode;
        logic crv_done;
        logic out_free;
    } dp_stat_t;

    localparam int DVD_W = 24;  // dividend and quotient width
    localparam int DSR_W = 23;  // divisor and remainder width
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] CNT_ADC  = 5'd16;
    localparam logic [CNT_W-1:0] CNT_SLOT = 5'd8;
    localparam logic [CNT_W-1:0] CNT_FULL = 5'd24;

    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [15:0] MV_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

@@ hdl/bclm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the monitor datapath.
// Depends on bclm_pkg for widths.
`default_nettype none

module bclm_div import bclm_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DSR_W-1:0] rem_init,
    input  wire logic [DVD_W-1:0] dvd_init,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  busy,
    output logic [DVD_W-1:0]      quotient,
    output logic [DSR_W-1:0]      remainder
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= count;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            dvd_reg <= dvd_init;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DSR_W'(trial - {1'b0, dsr_reg}) : DSR_W'(trial);
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ hdl/bclm_ctrl.sv @@
// Sequencer of the monitor: input handshake and the per-item command steps.
// Depends on bclm_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module bclm_ctrl import bclm_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_kind,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (item_kind_t'(s_kind))
                        KIND_ADC:     state_next = S_ADC_MUL;
                        KIND_MV:      state_next = S_TAKE;
                        KIND_CHARGER: state_next = S_CHARGER;
                        default:      state_next = S_POINT;
                    endcase
                end
            end
            S_ADC_MUL:   state_next = S_ADC_DIV;
            S_ADC_DIV:   state_next = S_ADC_WAIT;
            S_ADC_WAIT:  if (!stat.div_busy) state_next = S_TAKE;
            S_TAKE:      state_next = S_SLOT_WAIT;
            S_SLOT_WAIT: if (!stat.div_busy) state_next = S_SUM_RD;
            S_SUM_RD:    state_next = S_SUM_ACC;
            S_SUM_ACC:   state_next = stat.sum_last ? S_AVG_DIV : S_SUM_RD;
            S_AVG_DIV:   state_next = S_AVG_WAIT;
            S_AVG_WAIT:  if (!stat.div_busy) state_next = S_CELL_DIV;
            S_CELL_DIV:  state_next = S_CELL_WAIT;
            S_CELL_WAIT: if (!stat.div_busy) state_next = S_PCT_SEL;
            S_PCT_SEL:   state_next = stat.curve_mode ? S_CRV_LAST : S_PCT_WAIT;
            S_CRV_LAST:  state_next = S_CRV_LRD;
            S_CRV_LRD:   state_next = S_CRV_LCAP;
            S_CRV_LCAP:  state_next = S_CRV_RD;
            S_CRV_RD:    state_next = S_CRV_CHK;
            S_CRV_CHK:   state_next = stat.crv_done ? S_PCT_WAIT : S_CRV_RD;
            S_PCT_WAIT:  if (!stat.div_busy) state_next = S_REFRESH;
            S_REFRESH:   state_next = S_RESULT;
            S_CHARGER:   state_next = S_RESULT;
            S_POINT:     state_next = S_RESULT;
            S_RESULT:    if (stat.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_ADC_MUL:   cmd.op = OP_ADC_MUL;
            S_ADC_DIV:   cmd.op = OP_ADC_DIV;
            S_TAKE:      cmd.op = OP_TAKE;
            S_SLOT_WAIT: if (!stat.div_busy) cmd.op = OP_SLOT;
            S_SUM_ACC:   cmd.op = OP_SUM;
            S_AVG_DIV:   cmd.op = OP_AVG_DIV;
            S_AVG_WAIT:  if (!stat.div_busy) cmd.op = OP_AVG;
            S_CELL_DIV:  cmd.op = OP_CELL_DIV;
            S_CELL_WAIT: if (!stat.div_busy) cmd.op = OP_CELL;
            S_PCT_SEL:   if (!stat.curve_mode) cmd.op = OP_LIN;
            S_CRV_LAST:  cmd.op = OP_CRV_LAST;
            S_CRV_LCAP:  cmd.op = OP_CRV_FIRST;
            S_CRV_CHK:   cmd.op = OP_CRV_CHK;
            S_PCT_WAIT:  if (!stat.div_busy) cmd.op = OP_PCT_END;
            S_REFRESH:   cmd.op = OP_REFRESH;
            S_CHARGER:   cmd.op = OP_CHARGER;
            S_POINT:     cmd.op = OP_POINT;
            S_RESULT:    if (stat.out_free) cmd.op = OP_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/bclm_dp.sv @@
// Datapath of the monitor: registers, sample window, curve table, divider.
// Depends on bclm_pkg, bclm_div and the assertion macro header.
`default_nettype none
`include "battery_charge_level_monitor_defines.svh"

module bclm_dp import bclm_pkg::*; #(
    parameter int MAX_WINDOW       = 16,
    parameter int MAX_CURVE_POINTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_charging_now,
    input  wire logic [2:0]  s_point_index,
    input  wire logic [15:0] s_point_mv,
    input  wire logic [6:0]  s_point_percent,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_raw_mv,
    output logic [15:0]      m_smooth_mv,
    output logic [6:0]       m_charge_percent,
    output logic [2:0]       m_battery_state,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat
);

    localparam int WW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WCW = $clog2(MAX_WINDOW + 1);
    localparam int SW  = 16 + WCW;
    localparam int CW  = $clog2(MAX_CURVE_POINTS);
    localparam int NW  = $clog2(MAX_CURVE_POINTS + 1);

    function automatic logic [6:0] clamp100(input logic [DVD_W-1:0] p);
        return (p > DVD_W'(PCT_FULL)) ? PCT_FULL : p[6:0];
    endfunction

    function automatic bat_state_t refresh(input bat_state_t cur, input logic chg,
                                           input logic [15:0] filt, input logic [6:0] pct,
                                           input logic [18:0] low);
        bat_state_t res;
        res = cur;
        if (filt != 16'd0) begin
            if (pct >= PCT_FULL) res = BS_FULL;
            else if (!chg) res = (19'(filt) <= low) ? BS_LOW : BS_NORMAL;
        end
        return res;
    endfunction

    // configuration
    logic [2:0]       cell_count_reg;
    logic [15:0]      cell_full_reg, cell_empty_reg, cell_low_reg;
    logic [31:0]      adc_num_reg;
    logic [DSR_W-1:0] adc_den_reg;
    logic [4:0]       window_len_reg;
    logic [3:0]       curve_points_reg;

    // captured item
    logic [1:0]  kind_reg;
    logic [15:0] sample_reg;
    logic        chg_reg;
    logic [2:0]  pidx_reg;
    logic [15:0] pmv_reg;
    logic [6:0]  ppct_reg;

    // control state
    logic [WW-1:0]  slot_reg;
    logic [WCW-1:0] filled_reg;
    logic [15:0]    last_raw_reg, filtered_reg;
    logic [6:0]     pct_reg;
    bat_state_t     status_reg;
    logic           charger_reg;
    logic           m_valid_reg;

    // working registers
    logic [47:0]    prod_reg;
    logic           sat_reg;
    logic [SW-1:0]  sum_reg;
    logic [WW-1:0]  idx_reg;
    logic [15:0]    c_reg;
    logic           pend_reg;
    logic [6:0]     base_reg;
    logic [CW-1:0]  caddr_reg;
    logic [15:0]    vh_reg, last_mv_reg;
    logic [6:0]     ph_reg, last_pct_reg;
    logic [15:0]    m_raw_reg, m_smooth_reg;
    logic [6:0]     m_pct_reg;
    logic [2:0]     m_state_reg;

    // memories
    logic [15:0]      win_mem [MAX_WINDOW];
    logic [15:0]      win_q;
    logic [DSR_W-1:0] crv_mem [MAX_CURVE_POINTS];
    logic [DSR_W-1:0] crv_q;

    // divider
    logic             div_start, div_busy;
    logic [DSR_W-1:0] div_rem_init, div_dsr, div_rem;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [CNT_W-1:0] div_cnt;

    // derived values
    logic [2:0]       cc;
    logic [WCW-1:0]   w_eff;
    logic [NW-1:0]    n_eff;
    logic [CW-1:0]    n_last;
    logic [DSR_W-1:0] den_eff;
    logic [18:0]      low_mv;
    logic             adc_sat;
    logic [15:0]      take_mv;
    logic [7:0]       slot_inc;
    logic             lin_start;
    logic [6:0]       lin_pct;
    logic [15:0]      lin_den;
    logic [DVD_W-1:0] lin_num;
    logic [15:0]      cur_mv;
    logic [6:0]       cur_pct;
    logic             crv_done, crv_start;
    logic [6:0]       crv_pct;
    logic [15:0]      vr;
    logic [DVD_W-1:0] crv_num;
    logic             bracket;

    assign cc      = (cell_count_reg == 3'd0) ? 3'd1 :
                     (cell_count_reg > 3'd4) ? 3'd4 : cell_count_reg;
    assign w_eff   = (window_len_reg == 5'd0) ? WCW'(1) :
                     (32'(window_len_reg) > MAX_WINDOW) ? WCW'(MAX_WINDOW) :
                     WCW'(window_len_reg);
    assign n_eff   = (32'(curve_points_reg) > MAX_CURVE_POINTS) ? NW'(MAX_CURVE_POINTS) :
                     NW'(curve_points_reg);
    assign n_last  = CW'(n_eff - NW'(1));
    assign den_eff = (adc_den_reg == '0) ? DSR_W'(1) : adc_den_reg;
    assign low_mv  = 19'(cell_low_reg) * 19'(cc);
    assign adc_sat = prod_reg[47:16] >= 32'(den_eff);
    assign take_mv = (item_kind_t'(kind_reg) == KIND_ADC) ?
                     (sat_reg ? MV_MAX : div_q[15:0]) : sample_reg;
    assign slot_inc = 8'(slot_reg) + 8'd1;

    // linear mode
    assign lin_den = cell_full_reg - cell_empty_reg;
    assign lin_num = DVD_W'(c_reg - cell_empty_reg) * DVD_W'(7'd100) + DVD_W'(lin_den >> 1);
    always_comb begin
        lin_start = 1'b0;
        lin_pct   = 7'd0;
        if (c_reg >= cell_full_reg) lin_pct = PCT_FULL;
        else if (c_reg > cell_empty_reg) lin_start = 1'b1;
    end

    // curve scan: entry caddr_reg against the previous one
    assign cur_mv  = crv_q[DSR_W-1:7];
    assign cur_pct = crv_q[6:0];
    assign vr      = vh_reg - cur_mv;
    assign bracket = (c_reg <= vh_reg) && (c_reg >= cur_mv);
    assign crv_num = DVD_W'(c_reg - cur_mv) * DVD_W'(ph_reg - cur_pct) + DVD_W'(vr >> 1);
    always_comb begin
        crv_done  = 1'b0;
        crv_start = 1'b0;
        crv_pct   = 7'd0;
        if (caddr_reg == '0) begin
            if (c_reg >= cur_mv) begin
                crv_done = 1'b1;
                crv_pct  = clamp100(DVD_W'(cur_pct));
            end else if (c_reg <= last_mv_reg) begin
                crv_done = 1'b1;
                crv_pct  = clamp100(DVD_W'(last_pct_reg));
            end
        end else if (bracket) begin
            crv_done = 1'b1;
            if (vr == 16'd0 || ph_reg < cur_pct) crv_pct = clamp100(DVD_W'(cur_pct));
            else crv_start = 1'b1;
        end else if (caddr_reg == n_last) begin
            crv_done = 1'b1;
        end
    end

    // divider operand selection
    always_comb begin
        div_start    = 1'b0;
        div_rem_init = '0;
        div_dvd      = '0;
        div_cnt      = CNT_FULL;
        div_dsr      = den_eff;
        case (cmd.op)
            OP_ADC_DIV: begin
                div_start    = !adc_sat;
                div_rem_init = DSR_W'(prod_reg[47:16]);
                div_dvd      = {prod_reg[15:0], 8'd0};
                div_cnt      = CNT_ADC;
            end
            OP_TAKE: begin
                div_start = 1'b1;
                div_dvd   = {slot_inc, 16'd0};
                div_cnt   = CNT_SLOT;
                div_dsr   = DSR_W'(w_eff);
            end
            OP_AVG_DIV: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(sum_reg);
                div_dsr   = DSR_W'(filled_reg);
            end
            OP_CELL_DIV: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(filtered_reg) + DVD_W'(cc >> 1);
                div_dsr   = DSR_W'(cc);
            end
            OP_LIN: begin
                div_start = lin_start;
                div_dvd   = lin_num;
                div_dsr   = DSR_W'(lin_den);
            end
            OP_CRV_CHK: begin
                div_start = crv_start;
                div_dvd   = crv_num;
                div_dsr   = DSR_W'(vr);
            end
            default: div_start = 1'b0;
        endcase
    end

    bclm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .dvd_init  (div_dvd),
        .count     (div_cnt),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg   <= 3'd1;
            cell_full_reg    <= 16'd4200;
            cell_empty_reg   <= 16'd3300;
            cell_low_reg     <= 16'd3500;
            adc_num_reg      <= 32'd660000;
            adc_den_reg      <= 23'd409600;
            window_len_reg   <= 5'd1;
            curve_points_reg <= 4'd0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_CELL_COUNT:   cell_count_reg   <= cfg_data[2:0];
                REG_CELL_FULL:    cell_full_reg    <= cfg_data[15:0];
                REG_CELL_EMPTY:   cell_empty_reg   <= cfg_data[15:0];
                REG_CELL_LOW:     cell_low_reg     <= cfg_data[15:0];
                REG_ADC_NUM:      adc_num_reg      <= cfg_data;
                REG_ADC_DEN:      adc_den_reg      <= cfg_data[DSR_W-1:0];
                REG_WINDOW_LEN:   window_len_reg   <= cfg_data[4:0];
                REG_CURVE_POINTS: curve_points_reg <= cfg_data[3:0];
                default:          cell_count_reg   <= cell_count_reg;
            endcase
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_TAKE) win_mem[slot_reg] <= take_mv;
        win_q <= win_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_POINT && 32'(pidx_reg) < MAX_CURVE_POINTS)
            crv_mem[CW'(pidx_reg)] <= {pmv_reg, ppct_reg};
        crv_q <= crv_mem[caddr_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            filled_reg   <= '0;
            last_raw_reg <= '0;
            filtered_reg <= '0;
            pct_reg      <= '0;
            status_reg   <= BS_UNKNOWN;
            charger_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.op == OP_OUT) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_TAKE: begin
                    last_raw_reg <= take_mv;
                    if (filled_reg < w_eff) filled_reg <= filled_reg + WCW'(1);
                end
                OP_SLOT:    slot_reg     <= WW'(div_rem);
                OP_AVG:     filtered_reg <= div_q[15:0];
                OP_LIN:     pct_reg      <= lin_pct;
                OP_CRV_CHK: if (crv_done) pct_reg <= crv_pct;
                OP_PCT_END: if (pend_reg) pct_reg <= clamp100(DVD_W'(base_reg) + div_q);
                OP_REFRESH: status_reg <= refresh(status_reg, charger_reg, filtered_reg,
                                                  pct_reg, low_mv);
                OP_CHARGER: begin
                    charger_reg <= chg_reg;
                    if (chg_reg) status_reg <= BS_CHARGING;
                    else if (status_reg == BS_CHARGING || status_reg == BS_FULL)
                        status_reg <= refresh(status_reg, 1'b0, filtered_reg, pct_reg, low_mv);
                end
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            sample_reg <= s_sample;
            chg_reg    <= s_charging_now;
            pidx_reg   <= s_point_index;
            pmv_reg    <= s_point_mv;
            ppct_reg   <= s_point_percent;
        end
        case (cmd.op)
            OP_ADC_MUL: prod_reg <= 48'(sample_reg) * 48'(adc_num_reg);
            OP_ADC_DIV: sat_reg  <= adc_sat;
            OP_SLOT: begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            OP_SUM: begin
                sum_reg <= sum_reg + SW'(win_q);
                idx_reg <= idx_reg + WW'(1);
            end
            OP_CELL: c_reg <= div_q[15:0];
            OP_LIN: begin
                pend_reg <= lin_start;
                base_reg <= 7'd0;
            end
            OP_CRV_LAST: caddr_reg <= n_last;
            OP_CRV_FIRST: begin
                last_mv_reg  <= cur_mv;
                last_pct_reg <= cur_pct;
                caddr_reg    <= '0;
            end
            OP_CRV_CHK: begin
                vh_reg    <= cur_mv;
                ph_reg    <= cur_pct;
                caddr_reg <= caddr_reg + CW'(1);
                pend_reg  <= crv_start;
                base_reg  <= cur_pct;
            end
            OP_OUT: begin
                m_raw_reg    <= last_raw_reg;
                m_smooth_reg <= filtered_reg;
                m_pct_reg    <= pct_reg;
                m_state_reg  <= status_reg;
            end
            default: base_reg <= base_reg;
        endcase
    end

    assign stat.div_busy   = div_busy;
    assign stat.sum_last   = WCW'(idx_reg) + WCW'(1) == filled_reg;
    assign stat.curve_mode = n_eff >= NW'(2);
    assign stat.crv_done   = crv_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_raw_mv         = m_raw_reg;
    assign m_smooth_mv      = m_smooth_reg;
    assign m_charge_percent = m_pct_reg;
    assign m_battery_state  = m_state_reg;

    `BCLM_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
    `BCLM_ASSERT_NEXT(a_filled_after_take, cmd.op == OP_TAKE, filled_reg != '0, "window empty after sample")
    `BCLM_ASSERT_NEXT(a_charger_state, cmd.op == OP_CHARGER && chg_reg, status_reg == BS_CHARGING, "charger on not reported")

endmodule

`default_nettype wire

@@ hdl/battery_charge_level_monitor.sv @@
// Top level of the battery charge level monitor.
// Depends on bclm_pkg, bclm_ctrl and bclm_dp.
//
// Takes one item at a time: ADC code, pack mV, charger event or curve point,
// and returns one result per item holding the state after that item. Charger
// events and curve writes run no division. A pack mV sample runs the window
// wrap, a sum over the filled slots, the average, the per-cell and, in linear
// mode, the percent division, skipped when the cell voltage lies outside the
// empty..full span; an ADC code adds the ADC scale division (skipped when it
// saturates); curve mode adds a scan over at most n curve entries and skips
// the percent division when the voltage hits a curve end or a flat segment.
// A stalled result port adds its stall. Time per item is set by the shared
// one-bit-per-cycle divider (ADC scale, window wrap, average, per-cell and
// percent divisions) and the single read port of window and curve memories.
`default_nettype none

module battery_charge_level_monitor import bclm_pkg::*; #(
    parameter int MAX_WINDOW       = 16,
    parameter int MAX_CURVE_POINTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_charging_now,
    input  wire logic [2:0]  s_point_index,
    input  wire logic [15:0] s_point_mv,
    input  wire logic [6:0]  s_point_percent,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_raw_mv,
    output logic [15:0]      m_smooth_mv,
    output logic [6:0]       m_charge_percent,
    output logic [2:0]       m_battery_state
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bclm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .stat    (stat),
        .cmd     (cmd)
    );

    bclm_dp #(
        .MAX_WINDOW       (MAX_WINDOW),
        .MAX_CURVE_POINTS (MAX_CURVE_POINTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_kind           (s_kind),
        .s_sample         (s_sample),
        .s_charging_now   (s_charging_now),
        .s_point_index    (s_point_index),
        .s_point_mv       (s_point_mv),
        .s_point_percent  (s_point_percent),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_raw_mv         (m_raw_mv),
        .m_smooth_mv      (m_smooth_mv),
        .m_charge_percent (m_charge_percent),
        .m_battery_state  (m_battery_state),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

`default_nettype wire
